// ===== sv/bnv_pkg.sv =====
// Package for the birth number validator: verdict codes, character codes,
// position constants and the small arithmetic helpers.
// Depends on nothing.
package bnv_pkg;

  localparam int unsigned VerdictWidth = 2;

  localparam logic [VerdictWidth-1:0] VERDICT_INVALID = 2'd0;
  localparam logic [VerdictWidth-1:0] VERDICT_BOY     = 2'd1;
  localparam logic [VerdictWidth-1:0] VERDICT_GIRL    = 2'd2;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam logic [4:0] POS_SLASH     = 5'd6;
  localparam logic [4:0] POS_MONTH     = 5'd2;
  localparam logic [4:0] POS_DAY       = 5'd4;
  localparam logic [4:0] LAST_IDX_SHORT = 5'd9;
  localparam logic [4:0] LAST_IDX_LONG  = 5'd10;

  localparam logic [1:0] SLASH_MAX = 2'd3;

  localparam logic [6:0] YEAR_TEEN_LOW  = 7'd10;
  localparam logic [6:0] YEAR_TEEN_HIGH = 7'd19;
  localparam logic [6:0] YEAR_SHORT_MAX = 7'd53;
  localparam logic [6:0] GIRL_OFFSET    = 7'd50;
  localparam logic [4:0] LEAP_DAY       = 5'd29;
  localparam logic [3:0] FEBRUARY       = 4'd2;

  typedef struct packed {
    logic [4:0] position;
    logic [1:0] slash_total;
    logic       slash_misplaced;
    logic       bad_character;
    logic [6:0] year_pair;
    logic [6:0] month_pair;
    logic [6:0] day_pair;
    logic [3:0] remainder_eleven;
  } scan_t;

  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  // Ten times the old remainder is minus the old remainder modulo eleven.
  function automatic logic [3:0] mod11_step(input logic [3:0] rem, input logic [3:0] digit);
    logic [4:0] wrapped;
    wrapped = {1'b0, digit} + 5'd11 - {1'b0, rem};
    return (digit >= rem) ? (digit - rem) : wrapped[3:0];
  endfunction

  function automatic logic [6:0] pair_step(input logic [6:0] pair, input logic [3:0] digit);
    logic [9:0] wide;
    wide = {pair, 3'b000} + {2'b00, pair, 1'b0} + {6'd0, digit};
    return wide[6:0];
  endfunction

endpackage

// ===== sv/bnv_char_if.sv =====
// Channel that carries one character request of the ID string.
// Depends on nothing.
interface bnv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/bnv_verdict_if.sv =====
// Channel that carries one verdict request per ID string.
// Depends on nothing.
interface bnv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ===== sv/birth_number_validator_top.sv =====
// Birth number validator: scans an ID string one character a cycle and
// gives one verdict per string. Depends on bnv_pkg, bnv_char_if, bnv_verdict_if.
//
// One character is accepted in every cycle, also while a finished verdict
// waits to be taken. A character passes an input register and then updates
// the scan state; on the final character the verdict is formed in the same
// pass and is written to the result register, from which it is taken. Only a
// final character stalls, and only when the result register still holds a
// verdict that has not been taken.
module birth_number_validator_top import bnv_pkg::*; (
  input logic           clk,
  input logic           rst,
  bnv_char_if.sink      chars,
  bnv_verdict_if.source verdicts
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       advance;

  scan_t      scan;
  scan_t      scan_next;

  logic       out_valid;
  logic [1:0] out_verdict;
  logic [1:0] verdict_next;

  logic [7:0] char_offset;
  logic [3:0] digit;
  logic       is_digit;
  logic       is_slash;

  logic [6:0] month_base;
  logic [3:0] month_idx;
  logic       month_ok;
  logic       is_girl;
  logic       leap;
  logic       day_ok;
  logic       year_ok;
  logic       year_short;
  logic       length_ok;

  assign advance      = s1_valid && (!s1_last || !out_valid || verdicts.ready);
  assign chars.ready  = !s1_valid || advance;
  assign verdicts.valid   = out_valid;
  assign verdicts.verdict = out_verdict;

  assign char_offset = s1_char - CHAR_ZERO;
  assign digit       = char_offset[3:0];
  assign is_digit    = (s1_char >= CHAR_ZERO) && (s1_char <= CHAR_NINE);
  assign is_slash    = (s1_char == CHAR_SLASH);

  always_comb begin
    scan_next = scan;
    if (is_slash) begin
      if (scan.slash_total != SLASH_MAX) begin
        scan_next.slash_total = scan.slash_total + 2'd1;
      end
      if (scan.position != POS_SLASH) begin
        scan_next.slash_misplaced = 1'b1;
      end
    end else if (is_digit) begin
      if (scan.position < POS_MONTH) begin
        scan_next.year_pair = pair_step(scan.year_pair, digit);
      end else if (scan.position < POS_DAY) begin
        scan_next.month_pair = pair_step(scan.month_pair, digit);
      end else if (scan.position < POS_SLASH) begin
        scan_next.day_pair = pair_step(scan.day_pair, digit);
      end
      scan_next.remainder_eleven = mod11_step(scan.remainder_eleven, digit);
    end else begin
      scan_next.bad_character = 1'b1;
    end
    if (scan.position != POS_MAX) begin
      scan_next.position = scan.position + 5'd1;
    end
  end

  // The century adds a multiple of four, so the leap rule rests on the pair alone.
  assign is_girl    = (scan_next.month_pair > GIRL_OFFSET);
  assign month_base = is_girl ? (scan_next.month_pair - GIRL_OFFSET) : scan_next.month_pair;
  assign month_idx  = month_base[3:0];
  assign month_ok   = (month_base >= 7'd1) && (month_base <= 7'd12);
  assign leap       = (scan_next.year_pair[1:0] == 2'b00);
  assign day_ok     = (scan_next.day_pair != 7'd0) &&
                      ((scan_next.day_pair <= {2'b00, month_days(month_idx)}) ||
                       (month_idx == FEBRUARY && scan_next.day_pair == {2'b00, LEAP_DAY} &&
                        leap));
  assign year_ok    = !((scan_next.year_pair >= YEAR_TEEN_LOW) &&
                        (scan_next.year_pair <= YEAR_TEEN_HIGH));
  assign year_short = (scan_next.year_pair > YEAR_TEEN_HIGH) &&
                      (scan_next.year_pair <= YEAR_SHORT_MAX);
  assign length_ok  = year_short ? (scan.position == LAST_IDX_SHORT) :
                      ((scan.position == LAST_IDX_LONG) &&
                       (scan_next.remainder_eleven == 4'd0));

  always_comb begin
    verdict_next = VERDICT_INVALID;
    if (!scan_next.bad_character && scan_next.slash_total == 2'd1 &&
        !scan_next.slash_misplaced && year_ok && month_ok && day_ok && length_ok) begin
      verdict_next = is_girl ? VERDICT_GIRL : VERDICT_BOY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_last <= chars.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (advance) begin
      scan <= s1_last ? '0 : scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_verdict <= verdict_next;
    end
  end

endmodule

// ===== sv/bnv_checker.sv =====
// Port-level checks for the birth number validator, bound to the top level.
// Depends on bnv_pkg and on the top level's channel signals.
module bnv_checker import bnv_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input logic       char_last,
  input logic       verdict_valid,
  input logic       verdict_ready,
  input logic [1:0] verdict
);

  // A waiting verdict holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict))
    else $error("verdict changed or dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict == VERDICT_INVALID || verdict == VERDICT_BOY ||
                       verdict == VERDICT_GIRL))
    else $error("verdict code out of range");

  // A fresh verdict follows an accepted final character.
  assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(char_valid && char_ready && char_last, 2))
    else $error("verdict without a final character");

  // With the result register empty, characters are never held off.
  assert property (@(posedge clk) disable iff (rst)
    !verdict_valid |-> char_ready)
    else $error("input stalled while no verdict waits");

endmodule

bind birth_number_validator_top bnv_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (chars.valid),
  .char_ready   (chars.ready),
  .char_last    (chars.last_char),
  .verdict_valid(verdicts.valid),
  .verdict_ready(verdicts.ready),
  .verdict      (verdicts.verdict)
);

// ===== dv/birth_number_validator_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for the birth number validator: random and directed ID strings
// against a scoreboard that predicts each verdict. Depends on bnv_pkg,
// bnv_char_if, bnv_verdict_if and birth_number_validator_top.
module birth_number_validator_top_test import bnv_pkg::*; ();

  localparam int unsigned CycleLimit = 500000;

  class verdict_scoreboard;
    logic [4:0] pos;
    logic [1:0] slashes;
    logic       slash_off;
    logic       foreign;
    logic [6:0] yy;
    logic [6:0] mm;
    logic [6:0] dd;
    logic [3:0] rem11;
    logic [VerdictWidth-1:0] verdicts_due[$];
    int unsigned mismatches;

    function new();
      clear_scan();
      mismatches = 0;
    endfunction

    function void clear_scan();
      pos = '0;
      slashes = '0;
      slash_off = 1'b0;
      foreign = 1'b0;
      yy = '0;
      mm = '0;
      dd = '0;
      rem11 = '0;
    endfunction

    function logic [VerdictWidth-1:0] verdict_for(input int unsigned len);
      int unsigned full_year;
      int unsigned month;
      int unsigned days;
      bit leap;
      if (foreign || slashes != 2'd1 || slash_off) return VERDICT_INVALID;
      if (yy >= 7'd10 && yy <= 7'd19) return VERDICT_INVALID;
      full_year = (yy < 7'd10) ? 2000 + yy : 1900 + yy;
      if (!((mm >= 7'd1 && mm <= 7'd12) || (mm >= 7'd51 && mm <= 7'd62))) begin
        return VERDICT_INVALID;
      end
      month = mm % 50;
      leap = (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
      case (month)
        2: begin
          days = leap ? 29 : 28;
        end
        4, 6, 9, 11: begin
          days = 30;
        end
        default: begin
          days = 31;
        end
      endcase
      if (dd == 7'd0 || dd > days) return VERDICT_INVALID;
      if (full_year <= 1953) begin
        if (len != 10) return VERDICT_INVALID;
      end else begin
        if (len != 11 || rem11 != 4'd0) return VERDICT_INVALID;
      end
      return (mm >= 7'd50) ? VERDICT_GIRL : VERDICT_BOY;
    endfunction

    function void note_char(input logic [7:0] code, input logic fin);
      int unsigned here;
      int unsigned digit;
      here = pos;
      if (code == CHAR_SLASH) begin
        if (slashes != SLASH_MAX) slashes = slashes + 2'd1;
        if (here != 6) slash_off = 1'b1;
      end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
        digit = code - CHAR_ZERO;
        if (here < 2) yy = 7'((yy * 10 + digit) % 128);
        else if (here < 4) mm = 7'((mm * 10 + digit) % 128);
        else if (here < 6) dd = 7'((dd * 10 + digit) % 128);
        rem11 = 4'((rem11 * 10 + digit) % 11);
      end else begin
        foreign = 1'b1;
      end
      if (pos != POS_MAX) pos = pos + 5'd1;
      if (fin) begin
        verdicts_due.push_back(verdict_for(here + 1));
        clear_scan();
      end
    endfunction

    function void check_verdict(input logic [VerdictWidth-1:0] got);
      logic [VerdictWidth-1:0] want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Verdict %0d arrived with none expected.", got);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Verdict mismatch: expected %0d, got %0d.", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycles = 0;
  int unsigned chars_sent = 0;
  bit calm = 1'b0;
  verdict_scoreboard sb;

  bnv_char_if chars();
  bnv_verdict_if verdicts();

  birth_number_validator_top dut (
    .clk(clk),
    .rst(rst),
    .chars(chars),
    .verdicts(verdicts)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && verdicts.valid && verdicts.ready) sb.check_verdict(verdicts.verdict);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Builds YYMMDD/ followed by three digits, or by four digits whose check
  // digit makes the ten digits divisible by eleven when the sum is wanted good.
  function automatic string make_id(input int yr, input int mo, input int dy,
                                    input bit long_form, input bit good_sum);
    string s;
    int tail;
    int rem;
    int check;
    s = $sformatf("%02d%02d%02d/", yr, mo, dy);
    if (!long_form) return {s, $sformatf("%03d", $urandom_range(0, 999))};
    do begin
      tail = $urandom_range(0, 999);
      rem = int'((longint'(yr) * 10000000 + mo * 100000 + dy * 1000 + tail) % 11);
    end while (good_sum && rem == 10);
    check = good_sum ? rem : $urandom_range(0, 9);
    return {s, $sformatf("%03d%01d", tail, check)};
  endfunction

  task automatic send_char(input logic [7:0] code, input logic fin);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars.valid <= 1'b1;
    chars.char_code <= code;
    chars.last_char <= fin;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sb.note_char(code, fin);
    chars_sent++;
    @(negedge clk);
  endtask

  // One character may be replaced by another byte or dropped altogether.
  task automatic send_text(input string s, input int hit = -1,
                           input logic [7:0] swap = 8'h00, input bit drop = 1'b0);
    for (int i = 0; i < s.len(); i++) begin
      if (drop && i == hit) continue;
      send_char((i == hit) ? swap : s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    chars.valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int steady;
    int stall;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 40)) begin
        stall = steady ? 0 : pick_gap();
        repeat (stall) begin
          @(negedge clk);
          verdicts.ready <= 1'b0;
        end
        @(negedge clk);
        verdicts.ready <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int yr;
    int mo;
    int dy;
    string s;
    bit drained_mid;
    sb = new();
    drained_mid = 1'b0;
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.char_code = 8'h00;
    chars.last_char = 1'b0;
    verdicts.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("5");
    send_text("/");
    send_text(make_id(45, 1, 1, 0, 1));
    send_text(make_id(53, 51, 31, 0, 1));
    send_text(make_id(0, 2, 29, 1, 1));
    send_text(make_id(96, 52, 29, 1, 1));
    send_text(make_id(99, 2, 29, 1, 1));
    send_text(make_id(15, 6, 15, 1, 1));
    send_text(make_id(54, 12, 31, 1, 0));
    send_text(make_id(20, 0, 10, 0, 1));
    send_text(make_id(20, 13, 10, 0, 1));
    send_text(make_id(20, 50, 10, 0, 1));
    send_text(make_id(20, 63, 10, 0, 1));
    send_text(make_id(30, 4, 31, 0, 1));
    send_text(make_id(30, 4, 0, 0, 1));
    send_text(make_id(9, 62, 31, 1, 1));
    send_text(make_id(53, 1, 1, 1, 1));
    send_text(make_id(54, 1, 1, 0, 1));
    send_text("45010/1123");
    send_text("450101//12");
    send_text("4501011234");
    send_text("45 101/123");
    send_text("+50101/123");
    send_text(make_id(45, 1, 1, 0, 1), 0, 8'h00);
    send_text(make_id(45, 1, 1, 0, 1), 3, 8'hFF);
    for (int i = 0; i < 40; i++) send_char(CHAR_ZERO + 8'(i % 10), i == 39);
    wait_drained();

    while (chars_sent < 1250) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!drained_mid && chars_sent >= 600) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
      end else begin
        yr = $urandom_range(0, 99);
        mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        if ($urandom_range(0, 9) == 0) begin
          mo = 2;
          dy = 29;
        end
        if (mo <= 12 && $urandom_range(0, 1) == 1) mo += 50;
        s = make_id(yr, mo, dy, (yr > 53 || yr < 10) ^ ($urandom_range(0, 9) == 0),
                    $urandom_range(0, 99) < 85);
        if (kind < 35) begin
          send_text(s, $urandom_range(0, s.len() - 2), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 2) == 0);
        end else begin
          send_text(s);
        end
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bnv_pkg.sv
sv/bnv_char_if.sv
sv/bnv_verdict_if.sv
sv/birth_number_validator_top.sv
sv/bnv_checker.sv
dv/birth_number_validator_top_test.sv
